// File: design/dlcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlcr_pkg: shared types and constants
// Register map, configuration bundle and per-tick control flags for the
// dual load cell reader.
// ----------------------------------------------------------------------------
package dlcr_pkg;

  localparam int RAW_W      = 24;
  localparam int OFFSET_W   = 24;
  localparam int SCALE_W    = 32;
  localparam int THRESH_W   = 16;
  localparam int WEIGHT_W   = 48;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    REG_OFFSET_LEFT  = 3'd0,
    REG_OFFSET_RIGHT = 3'd1,
    REG_SCALE_LEFT   = 3'd2,
    REG_SCALE_RIGHT  = 3'd3,
    REG_BIAS         = 3'd4,
    REG_THRESHOLD    = 3'd5,
    REG_MODE         = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [OFFSET_W-1:0]       offset_left;
    logic [OFFSET_W-1:0]       offset_right;
    logic signed [SCALE_W-1:0] scale_left;
    logic signed [SCALE_W-1:0] scale_right;
    logic signed [SCALE_W-1:0] bias;
    logic [THRESH_W-1:0]       threshold;
    logic                      mode;
  } cfg_t;

  // control flags of one tick as they leave the front end
  typedef struct packed {
    logic sck;
    logic reading;
  } tick_t;

  localparam int TICK_W = $bits(tick_t);

endpackage
`default_nettype wire

// File: design/dual_load_cell_reader_threshold_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_load_cell_reader_threshold_core: two-cell bridge converter reader
// Drives a shared serial clock to two converters, assembles both words and
// turns them into a saturated, thresholded Q31.16 force.
// ----------------------------------------------------------------------------
// Each input item is one half period of sck and gives exactly one result
// item. The block takes one item every clock: the front end only steps
// the phase counter and shifters, and the two arithmetic stages (one
// multiplier per channel, then the sum/clamp/compare) are pipelined, so a
// result passes the queue, stage 1 and the output register. A two-entry queue
// sits between front end and arithmetic; input is held off only once it
// fills while the output is stalled. Configuration takes effect on the
// next item and is meant to be written between frames with no item in
// flight.
module dual_load_cell_reader_threshold_core #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [dlcr_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [dlcr_pkg::PDATA_W-1:0]      pwdata,
  output logic      [dlcr_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              dout_left,
  input  wire logic                              dout_right,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   sck,
  output logic                                   reading_valid,
  output logic      [dlcr_pkg::RAW_W-1:0]        raw_left,
  output logic      [dlcr_pkg::RAW_W-1:0]        raw_right,
  output logic signed [dlcr_pkg::WEIGHT_W-1:0]   weight,
  output logic                                   stop
);
  import dlcr_pkg::*;

  localparam int Q_W = TICK_W + 2 * COUNT_BITS;

  cfg_t                  cfg;
  logic                  q_full;
  logic                  push;
  tick_t                 f_tick;
  logic [COUNT_BITS-1:0] f_word_l;
  logic [COUNT_BITS-1:0] f_word_r;
  logic                  q_valid;
  logic                  q_pop;
  logic [Q_W-1:0]        q_rdata;
  tick_t                 q_tick;
  logic [COUNT_BITS-1:0] q_word_l;
  logic [COUNT_BITS-1:0] q_word_r;

  assign pready = 1'b1;
  assign {q_tick, q_word_l, q_word_r} = q_rdata;

  dlcr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dlcr_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dout_left  (dout_left),
    .dout_right (dout_right),
    .q_full     (q_full),
    .push       (push),
    .tick       (f_tick),
    .word_left  (f_word_l),
    .word_right (f_word_r)
  );

  dlcr_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({f_tick, f_word_l, f_word_r}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  dlcr_back #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_tick        (q_tick),
    .q_word_left   (q_word_l),
    .q_word_right  (q_word_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sck           (sck),
    .reading_valid (reading_valid),
    .raw_left      (raw_left),
    .raw_right     (raw_right),
    .weight        (weight),
    .stop          (stop)
  );

endmodule
`default_nettype wire

// File: design/dlcr_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlcr_regs: configuration register bank
// APB-style write/read access to offsets, scales, bias, threshold and mode.
// ----------------------------------------------------------------------------
module dlcr_regs (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [dlcr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dlcr_pkg::PDATA_W-1:0] pwdata,
  output logic      [dlcr_pkg::PDATA_W-1:0] prdata,
  output dlcr_pkg::cfg_t              cfg
);
  import dlcr_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_left  <= OFFSET_W'(24'h800000);
      cfg.offset_right <= OFFSET_W'(24'h800000);
      cfg.scale_left   <= SCALE_W'(32'sd65536);
      cfg.scale_right  <= SCALE_W'(32'sd65536);
      cfg.bias         <= '0;
      cfg.threshold    <= '0;
      cfg.mode         <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_OFFSET_LEFT:  cfg.offset_left  <= pwdata[OFFSET_W-1:0];
        REG_OFFSET_RIGHT: cfg.offset_right <= pwdata[OFFSET_W-1:0];
        REG_SCALE_LEFT:   cfg.scale_left   <= $signed(pwdata[SCALE_W-1:0]);
        REG_SCALE_RIGHT:  cfg.scale_right  <= $signed(pwdata[SCALE_W-1:0]);
        REG_BIAS:         cfg.bias         <= $signed(pwdata[SCALE_W-1:0]);
        REG_THRESHOLD:    cfg.threshold    <= pwdata[THRESH_W-1:0];
        REG_MODE:         cfg.mode         <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFFSET_LEFT:  prdata = PDATA_W'(cfg.offset_left);
      REG_OFFSET_RIGHT: prdata = PDATA_W'(cfg.offset_right);
      REG_SCALE_LEFT:   prdata = PDATA_W'(unsigned'(cfg.scale_left));
      REG_SCALE_RIGHT:  prdata = PDATA_W'(unsigned'(cfg.scale_right));
      REG_BIAS:         prdata = PDATA_W'(unsigned'(cfg.bias));
      REG_THRESHOLD:    prdata = PDATA_W'(cfg.threshold);
      REG_MODE:         prdata = PDATA_W'(cfg.mode);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/dlcr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlcr_front: serial clock sequencer and data shifters
// Takes one pin sample per tick, drives sck, shifts both words in MSB
// first and tags the tick that closes a frame.
// ----------------------------------------------------------------------------
module dlcr_front #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  dout_left,
  input  wire logic                  dout_right,
  input  wire logic                  q_full,
  output logic                       push,
  output dlcr_pkg::tick_t            tick,
  output logic [COUNT_BITS-1:0]      word_left,
  output logic [COUNT_BITS-1:0]      word_right
);
  import dlcr_pkg::*;

  localparam int PH_W = $clog2(2 * COUNT_BITS + 2);
  localparam logic [PH_W-1:0] SAMPLE_END = PH_W'(2 * COUNT_BITS);
  localparam logic [PH_W-1:0] LAST_PHASE = PH_W'(2 * COUNT_BITS + 1);
  localparam logic [COUNT_BITS-1:0] TOP_FLIP = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic [PH_W-1:0]       phase;
  logic [COUNT_BITS-1:0] shift_left;
  logic [COUNT_BITS-1:0] shift_right;
  logic                  frame_end;
  logic                  sample;

  assign in_ready  = !q_full;
  assign push      = in_valid && in_ready;
  assign frame_end = (phase == LAST_PHASE);
  // pins are sampled on the low half of pulses 1..COUNT_BITS
  assign sample    = phase[0] && (phase < SAMPLE_END);

  always_comb begin
    tick.sck     = ~phase[0];
    tick.reading = frame_end;
    word_left    = shift_left ^ TOP_FLIP;
    word_right   = shift_right ^ TOP_FLIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      shift_left  <= '0;
      shift_right <= '0;
    end else if (push) begin
      if (phase >= LAST_PHASE) begin
        phase <= '0;
      end else begin
        if (sample) begin
          shift_left  <= {shift_left[COUNT_BITS-2:0], dout_left};
          shift_right <= {shift_right[COUNT_BITS-2:0], dout_right};
        end
        phase <= phase + PH_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: design/dlcr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlcr_fifo: short item queue
// Two-entry first-in first-out buffer between front end and arithmetic.
// ----------------------------------------------------------------------------
module dlcr_fifo #(
  parameter int WIDTH = 50
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);
  import dlcr_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/dlcr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlcr_back: force arithmetic and result register
// Offset removal and scaling in the first stage, sum, bias, saturation and
// threshold compare into the output register in the second.
// ----------------------------------------------------------------------------
module dlcr_back #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dlcr_pkg::cfg_t             cfg,
  input  wire logic                       q_valid,
  output logic                            q_pop,
  input  wire dlcr_pkg::tick_t            q_tick,
  input  wire logic [COUNT_BITS-1:0]      q_word_left,
  input  wire logic [COUNT_BITS-1:0]      q_word_right,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            sck,
  output logic                            reading_valid,
  output logic [dlcr_pkg::RAW_W-1:0]      raw_left,
  output logic [dlcr_pkg::RAW_W-1:0]      raw_right,
  output logic signed [dlcr_pkg::WEIGHT_W-1:0] weight,
  output logic                            stop
);
  import dlcr_pkg::*;

  localparam int MAX_W = (COUNT_BITS > OFFSET_W) ? COUNT_BITS : OFFSET_W;
  localparam int DIFF_W = MAX_W + 1;
  localparam int PROD_W = DIFF_W + SCALE_W;
  localparam int SUM_W  = (PROD_W + 2 > WEIGHT_W + 1) ? PROD_W + 2 : WEIGHT_W + 1;
  localparam logic signed [SUM_W-1:0] W_MAX =
    {{(SUM_W-WEIGHT_W+1){1'b0}}, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] W_MIN =
    {{(SUM_W-WEIGHT_W+1){1'b1}}, {(WEIGHT_W-1){1'b0}}};

  logic [MAX_W-1:0]          word_l_m;
  logic [MAX_W-1:0]          word_r_m;
  logic signed [DIFF_W-1:0]  diff_l;
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [PROD_W-1:0]  prod_l_next;
  logic signed [PROD_W-1:0]  prod_r_next;

  logic                      s1_valid;
  tick_t                     s1_tick;
  logic [RAW_W-1:0]          s1_raw_l;
  logic [RAW_W-1:0]          s1_raw_r;
  logic signed [PROD_W-1:0]  s1_prod_l;
  logic signed [PROD_W-1:0]  s1_prod_r;

  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   lim;
  logic signed [SUM_W-1:0]   clamped;
  logic                      out_en;
  logic                      s1_load;
  logic                      s1_adv;

  assign out_en  = !out_valid || out_ready;
  assign s1_load = !s1_valid || out_en;
  assign s1_adv  = s1_valid && out_en;
  assign q_pop   = q_valid && s1_load;

  // stage 1: offset binary word minus offset, times Q.16 scale
  always_comb begin
    word_l_m    = MAX_W'(q_word_left);
    word_r_m    = MAX_W'(q_word_right);
    diff_l      = $signed({1'b0, word_l_m}) - $signed({1'b0, MAX_W'(cfg.offset_left)});
    diff_r      = $signed({1'b0, word_r_m}) - $signed({1'b0, MAX_W'(cfg.offset_right)});
    prod_l_next = diff_l * cfg.scale_left;
    prod_r_next = diff_r * cfg.scale_right;
  end

  // stage 2: the sum is exact, so comparing before the clamp gives the same flag
  always_comb begin
    sum = SUM_W'(s1_prod_l) + SUM_W'(s1_prod_r) + SUM_W'(cfg.bias);
    lim = $signed({{(SUM_W-THRESH_W-FRAC_BITS){1'b0}}, cfg.threshold,
                   {FRAC_BITS{1'b0}}});
    if (sum > W_MAX) begin
      clamped = W_MAX;
    end else if (sum < W_MIN) begin
      clamped = W_MIN;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid  <= q_valid;
      if (out_en)  out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_tick   <= q_tick;
      s1_raw_l  <= word_l_m[RAW_W-1:0];
      s1_raw_r  <= word_r_m[RAW_W-1:0];
      s1_prod_l <= prod_l_next;
      s1_prod_r <= prod_r_next;
    end
  end

  // ticks that close no frame carry zeros in every result field
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      sck           <= s1_tick.sck;
      reading_valid <= s1_tick.reading;
      if (s1_tick.reading) begin
        raw_left  <= s1_raw_l;
        raw_right <= s1_raw_r;
        weight    <= clamped[WEIGHT_W-1:0];
        stop      <= cfg.mode ? (sum < lim) : (sum > lim);
      end else begin
        raw_left  <= '0;
        raw_right <= '0;
        weight    <= '0;
        stop      <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/dlcr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlcr_checker: port-level checks
// Result channel behaviour of the reader as seen from its ports.
// ----------------------------------------------------------------------------
module dlcr_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              sck,
  input wire logic                              reading_valid,
  input wire logic [dlcr_pkg::RAW_W-1:0]        raw_left,
  input wire logic [dlcr_pkg::RAW_W-1:0]        raw_right,
  input wire logic signed [dlcr_pkg::WEIGHT_W-1:0] weight,
  input wire logic                              stop
);

  // a stalled result item holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight) && $stable(stop)
      && $stable(reading_valid) && $stable(sck))
    else $error("result item changed while stalled");

  // ticks that close no frame report zeros
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reading_valid |-> raw_left == '0 && raw_right == '0
      && weight == '0 && !stop)
    else $error("non-reading item carries data");

  // a reading completes on the low half of the final pulse
  a_read_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && reading_valid |-> !sck)
    else $error("reading completed with sck high");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind dual_load_cell_reader_threshold_core dlcr_checker u_dlcr_checker (.*);
`default_nettype wire

// File: test/dlcr_reading_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcr_reading_checker: in-order result check for the load cell reader
// Shadows register writes, steps its own frame sequencer and force
// arithmetic on every accepted tick item, and compares each result item.
// ----------------------------------------------------------------------------
module dlcr_reading_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [dlcr_pkg::PADDR_W-1:0]         paddr,
  input  logic [dlcr_pkg::PDATA_W-1:0]         pwdata,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 dout_left,
  input  logic                                 dout_right,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic                                 sck,
  input  logic                                 reading_valid,
  input  logic [dlcr_pkg::RAW_W-1:0]           raw_left,
  input  logic [dlcr_pkg::RAW_W-1:0]           raw_right,
  input  logic signed [dlcr_pkg::WEIGHT_W-1:0] weight,
  input  logic                                 stop,
  output int                                   mismatches,
  output int                                   pending
);
  import dlcr_pkg::*;

  localparam int FRAME_LAST = 2 * (RAW_W + 1) - 1;
  localparam logic [RAW_W-1:0] TOP_BIT = {1'b1, {(RAW_W - 1){1'b0}}};
  localparam longint WEIGHT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint WEIGHT_MIN = -WEIGHT_MAX - 1;

  typedef struct packed {
    logic                       sck;
    logic                       valid;
    logic [RAW_W-1:0]           raw_l;
    logic [RAW_W-1:0]           raw_r;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       stop;
  } tick_result_t;

  cfg_t             cfg;
  logic [5:0]       frame_pos;
  logic [RAW_W-1:0] word_l;
  logic [RAW_W-1:0] word_r;
  tick_result_t     expected_ticks[$];
  int               bad_count;

  // one half period of sck: shift on low ticks, finish the reading on the last
  function automatic tick_result_t step_converter_clock(logic bl, logic br);
    tick_result_t r;
    longint       force_sum;
    longint       limit;
    r = '0;
    r.sck = ~frame_pos[0];
    if (frame_pos > FRAME_LAST) begin
      frame_pos = '0;
    end else if (frame_pos == FRAME_LAST) begin
      r.valid = 1'b1;
      r.raw_l = word_l ^ TOP_BIT;
      r.raw_r = word_r ^ TOP_BIT;
      force_sum = (longint'(r.raw_l) - longint'(cfg.offset_left))
                  * longint'($signed(cfg.scale_left))
                + (longint'(r.raw_r) - longint'(cfg.offset_right))
                  * longint'($signed(cfg.scale_right))
                + longint'($signed(cfg.bias));
      if (force_sum > WEIGHT_MAX) force_sum = WEIGHT_MAX;
      if (force_sum < WEIGHT_MIN) force_sum = WEIGHT_MIN;
      limit = longint'(cfg.threshold) << 16;
      r.stop = cfg.mode ? (force_sum < limit) : (force_sum > limit);
      r.weight = force_sum[WEIGHT_W-1:0];
      frame_pos = '0;
    end else begin
      if (frame_pos[0] && frame_pos < 2 * RAW_W) begin
        word_l = {word_l[RAW_W-2:0], bl};
        word_r = {word_r[RAW_W-2:0], br};
      end
      frame_pos = frame_pos + 6'd1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (rst) begin
      cfg.offset_left  = 24'h800000;
      cfg.offset_right = 24'h800000;
      cfg.scale_left   = 32'sd65536;
      cfg.scale_right  = 32'sd65536;
      cfg.bias         = '0;
      cfg.threshold    = '0;
      cfg.mode         = 1'b0;
      frame_pos = '0;
      word_l = '0;
      word_r = '0;
      expected_ticks.delete();
      bad_count = 0;
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {sck, reading_valid, raw_left, raw_right, weight, stop};
        if (expected_ticks.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: result item with nothing outstanding", $time);
        end else begin
          want = expected_ticks.pop_front();
          if (want != got) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: mismatch  exp sck=%b vld=%b raw_l=%h raw_r=%h weight=%0d stop=%b",
                       $time, want.sck, want.valid, want.raw_l, want.raw_r, want.weight,
                       want.stop);
              $display("             got sck=%b vld=%b raw_l=%h raw_r=%h weight=%0d stop=%b",
                       got.sck, got.valid, got.raw_l, got.raw_r, got.weight, got.stop);
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_OFFSET_LEFT:  cfg.offset_left  = pwdata[OFFSET_W-1:0];
          REG_OFFSET_RIGHT: cfg.offset_right = pwdata[OFFSET_W-1:0];
          REG_SCALE_LEFT:   cfg.scale_left   = pwdata;
          REG_SCALE_RIGHT:  cfg.scale_right  = pwdata;
          REG_BIAS:         cfg.bias         = pwdata;
          REG_THRESHOLD:    cfg.threshold    = pwdata[THRESH_W-1:0];
          REG_MODE:         cfg.mode         = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_ticks.push_back(step_converter_clock(dout_left, dout_right));
      mismatches <= bad_count;
      pending <= expected_ticks.size();
    end
  end

endmodule

// File: test/tb_dual_load_cell_reader_threshold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_load_cell_reader_threshold_core: testbench for the load cell reader
// Feeds whole sck frames of pin samples under random sender gaps and
// receiver stalls, across reset, extreme and random register settings.
// ----------------------------------------------------------------------------
module tb_dual_load_cell_reader_threshold_core;
  import dlcr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_OFF     = 300;
  localparam int SETTLE       = 16;
  localparam int FRAME_TICKS  = 2 * (RAW_W + 1);
  localparam logic [RAW_W-1:0] TOP_BIT = {1'b1, {(RAW_W - 1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       psel       = 1'b0;
  logic                       penable    = 1'b0;
  logic                       pwrite     = 1'b0;
  logic [PADDR_W-1:0]         paddr      = '0;
  logic [PDATA_W-1:0]         pwdata     = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic                       dout_left  = 1'b0;
  logic                       dout_right = 1'b0;
  logic                       out_valid;
  logic                       out_ready  = 1'b1;
  logic                       sck;
  logic                       reading_valid;
  logic [RAW_W-1:0]           raw_left;
  logic [RAW_W-1:0]           raw_right;
  logic signed [WEIGHT_W-1:0] weight;
  logic                       stop;

  int               mismatches;
  int               pending;
  int               cycles = 0;
  bit               gaps_on = 1'b1;
  bit               hold_req = 1'b0;
  logic [RAW_W-1:0] off_l_now = 24'h800000;
  logic [RAW_W-1:0] off_r_now = 24'h800000;

  always #2 clk = ~clk;

  dual_load_cell_reader_threshold_core uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .dout_left(dout_left), .dout_right(dout_right),
    .out_valid(out_valid), .out_ready(out_ready),
    .sck(sck), .reading_valid(reading_valid), .raw_left(raw_left), .raw_right(raw_right),
    .weight(weight), .stop(stop)
  );

  dlcr_reading_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .dout_left(dout_left), .dout_right(dout_right),
    .out_valid(out_valid), .out_ready(out_ready),
    .sck(sck), .reading_valid(reading_valid), .raw_left(raw_left), .raw_right(raw_right),
    .weight(weight), .stop(stop),
    .mismatches(mismatches), .pending(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // word as sent on the pins; near-offset picks land close to zero force
  function automatic logic [RAW_W-1:0] pick_word(logic [RAW_W-1:0] off);
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h7FFFFF;
      3:       return 24'h800000;
      4, 5:    return (off ^ TOP_BIT) + 24'($urandom_range(0, 8)) - 24'd4;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 32'h000000;
      1:       return 32'hFFFFFF;
      2, 3:    return 32'($urandom_range(0, 24'hFFFFFF));
      default: return 32'h800000 + 32'($urandom_range(0, 512)) - 32'd256;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = 32'h0001_0000;
      2:    v = 32'hFFFF_0000;
      3:    v = 32'h0;
      4:    v = 32'h7FFF_FFFF;
      5:    v = 32'h8000_0000;
      6, 7: v = $urandom;
      default: begin
        v = $urandom_range(0, 262143);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_OFFSET_LEFT) off_l_now = val[RAW_W-1:0];
    if (idx == REG_OFFSET_RIGHT) off_r_now = val[RAW_W-1:0];
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] ol, input logic [31:0] orr,
                           input logic [31:0] sl, input logic [31:0] sr,
                           input logic [31:0] b, input logic [31:0] thr,
                           input logic [31:0] md);
    write_reg(REG_OFFSET_LEFT, ol);
    write_reg(REG_OFFSET_RIGHT, orr);
    write_reg(REG_SCALE_LEFT, sl);
    write_reg(REG_SCALE_RIGHT, sr);
    write_reg(REG_BIAS, b);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MODE, md);
    apb_idle();
  endtask

  task automatic randomise_regs();
    logic [31:0] thr;
    logic [31:0] b;
    case ($urandom_range(0, 9))
      0:       thr = 32'h0;
      1:       thr = 32'hFFFF;
      2, 3, 4: thr = $urandom_range(0, 65535);
      default: thr = $urandom_range(0, 200);
    endcase
    case ($urandom_range(0, 9))
      0:       b = 32'h7FFF_FFFF;
      1:       b = 32'h8000_0000;
      2, 3, 4: b = $urandom;
      default: b = (thr < 32768) ? (thr << 16) : $urandom;
    endcase
    write_all(pick_offset(), pick_offset(), pick_scale(), pick_scale(), b, thr,
              $urandom_range(0, 1));
  endtask

  task automatic send_tick(input logic bl, input logic br);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid   <= 1'b1;
    dout_left  <= bl;
    dout_right <= br;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender stops until every outstanding result item has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_frame(input logic [RAW_W-1:0] wl, input logic [RAW_W-1:0] wr,
                            input bit pause_mid);
    int   t;
    logic bl;
    logic br;
    for (t = 0; t < FRAME_TICKS; t++) begin
      bl = $urandom_range(0, 1);
      br = $urandom_range(0, 1);
      // pins are only sampled on low ticks of data pulses, MSB first
      if (t % 2 == 1 && t < 2 * RAW_W) begin
        bl = wl[RAW_W - 1 - (t - 1) / 2];
        br = wr[RAW_W - 1 - (t - 1) / 2];
      end
      if (pause_mid && t == FRAME_TICKS / 2) drain();
      send_tick(bl, br);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        n = 0;
        while (n < HOLD_OFF) begin
          @(posedge clk);
          n++;
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
          out_ready <= 1'b1;
        end
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_dual_load_cell_reader_threshold_core: FAIL");
      $finish;
    end
  end

  initial begin
    int ph;
    int fr;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset register values, extreme pin words
    send_frame(24'h000000, 24'hFFFFFF, 1'b0);
    send_frame(24'h7FFFFF, 24'h800000, 1'b0);
    drain();

    // positive saturation, mode below-threshold at full threshold
    write_all(32'h0, 32'hFFFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF, 32'h1);
    send_frame(24'h7FFFFF, 24'h800000, 1'b0);
    drain();

    // negative saturation, zero threshold
    write_all(32'hFFFFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h0, 32'h0);
    send_frame(24'h800000, 24'h7FFFFF, 1'b0);
    drain();

    // force exactly on the threshold: strict compare in both modes
    write_all(32'h123456, 32'h0ABCDE, $urandom, $urandom, 32'd100 << 16, 32'd100, 32'h0);
    send_frame(24'h123456 ^ TOP_BIT, 24'h0ABCDE ^ TOP_BIT, 1'b0);
    drain();
    write_reg(REG_MODE, 32'h1);
    apb_idle();
    send_frame(24'h123456 ^ TOP_BIT, 24'h0ABCDE ^ TOP_BIT, 1'b0);

    for (ph = 0; ph < 8; ph++) begin
      drain();
      randomise_regs();
      gaps_on = (ph != 4);
      for (fr = 0; fr < 3; fr++) begin
        if (ph == 2 && fr == 1) hold_req = 1'b1;
        send_frame(pick_word(off_l_now), pick_word(off_r_now), ph == 5 && fr == 2);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_dual_load_cell_reader_threshold_core: PASS");
    end else begin
      $display("tb_dual_load_cell_reader_threshold_core: FAIL");
    end
    $finish;
  end

endmodule
